FILE: hdl/subtitle_tag_highlighter_defines.svh
// ----------------------------------------------------------------------------
// Subtitle tag highlighter assertion macros
// Shared property shorthands, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBTITLE_TAG_HIGHLIGHTER_DEFINES_SVH
`define SUBTITLE_TAG_HIGHLIGHTER_DEFINES_SVH

// same-cycle implication
`define STH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sth assertion failed");

// next-cycle implication
`define STH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sth assertion failed");

`endif

FILE: hdl/sth_pkg.sv
// ----------------------------------------------------------------------------
// sth_pkg
// Types and character constants for the subtitle tag highlighter.
// ----------------------------------------------------------------------------
package sth_pkg;

	localparam int unsigned CharW = 16;

	localparam logic [CharW-1:0] ChOpen   = 16'h007B;
	localparam logic [CharW-1:0] ChClose  = 16'h007D;
	localparam logic [CharW-1:0] ChBslash = 16'h005C;
	localparam logic [CharW-1:0] ChLowN   = 16'h006E;
	localparam logic [CharW-1:0] ChUpN    = 16'h004E;
	localparam logic [CharW-1:0] ChLowH   = 16'h0068;
	localparam logic [CharW-1:0] ChUpH    = 16'h0048;
	localparam logic [CharW-1:0] ChAmp    = 16'h0026;
	localparam logic [CharW-1:0] ChLParen = 16'h0028;
	localparam logic [CharW-1:0] ChRParen = 16'h0029;
	localparam logic [CharW-1:0] ChComma  = 16'h002C;
	localparam logic [CharW-1:0] ChDot    = 16'h002E;
	localparam logic [CharW-1:0] ChPlus   = 16'h002B;
	localparam logic [CharW-1:0] ChMinus  = 16'h002D;
	localparam logic [CharW-1:0] ChZero   = 16'h0030;
	localparam logic [CharW-1:0] ChNine   = 16'h0039;

	typedef enum logic [2:0] {
		CLS_NORMAL = 3'd0,
		CLS_BRACE  = 3'd1,
		CLS_SEP    = 3'd2,
		CLS_TAG    = 3'd3,
		CLS_ERROR  = 3'd4,
		CLS_NUMBER = 3'd5,
		CLS_BREAK  = 3'd6
	} cls_t;

	typedef enum logic [1:0] {
		MODE_OUTSIDE = 2'd0,
		MODE_INSIDE  = 2'd1,
		MODE_ERROR   = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  held;
		logic  amp;
	} st_t;

	typedef struct packed {
		logic [CharW-1:0] ch;
		cls_t             cls;
		logic             eot;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

endpackage

FILE: hdl/sth_classify.sv
// ----------------------------------------------------------------------------
// sth_classify
// Per-character classifier: styles one character against the current state,
// releases a held backslash and computes the next state.
// ----------------------------------------------------------------------------
module sth_classify (
	input  logic [sth_pkg::CharW-1:0] ch,
	input  logic                      last,
	input  sth_pkg::st_t              st,
	output sth_pkg::res_pair_t        res,
	output sth_pkg::st_t              st_nxt
);

	always_comb begin
		logic           brk;
		logic           done;
		logic           hold;
		sth_pkg::cls_t  cls;
		sth_pkg::mode_t mode;
		sth_pkg::res_t  cur;

		brk  = (ch == sth_pkg::ChLowN) || (ch == sth_pkg::ChUpN) || (ch == sth_pkg::ChLowH);
		mode = st.mode;
		res  = '0;
		st_nxt = st;
		done = 1'b0;
		cur.ch  = ch;
		cur.eot = 1'b0;

		if (st.held) begin
			st_nxt.held = 1'b0;
			res.cnt = 2'd1;
			res.r0.ch  = sth_pkg::ChBslash;
			res.r0.eot = 1'b0;
			res.r0.cls = brk ? sth_pkg::CLS_BREAK : sth_pkg::CLS_NORMAL;
			if (brk) begin
				done = 1'b1;
				st_nxt.amp = 1'b0;
			end
		end

		hold = (mode == sth_pkg::MODE_OUTSIDE) && (ch == sth_pkg::ChBslash) && !last;

		// classification of the current character
		if (mode == sth_pkg::MODE_ERROR) begin
			cls = sth_pkg::CLS_ERROR;
		end else if (ch == sth_pkg::ChOpen) begin
			if (mode == sth_pkg::MODE_OUTSIDE) begin
				mode = sth_pkg::MODE_INSIDE;
				cls  = sth_pkg::CLS_BRACE;
			end else begin
				mode = sth_pkg::MODE_ERROR;
				cls  = sth_pkg::CLS_ERROR;
			end
		end else if (ch == sth_pkg::ChClose) begin
			if (mode == sth_pkg::MODE_INSIDE) begin
				mode = sth_pkg::MODE_OUTSIDE;
				cls  = sth_pkg::CLS_BRACE;
			end else begin
				mode = sth_pkg::MODE_ERROR;
				cls  = sth_pkg::CLS_ERROR;
			end
		end else if (mode == sth_pkg::MODE_OUTSIDE) begin
			cls = sth_pkg::CLS_NORMAL;
		end else if ((ch == sth_pkg::ChBslash) || (ch == sth_pkg::ChLParen) ||
			(ch == sth_pkg::ChRParen) || (ch == sth_pkg::ChComma)) begin
			cls = sth_pkg::CLS_SEP;
		end else if (((ch >= sth_pkg::ChZero) && (ch <= sth_pkg::ChNine)) ||
			(ch == sth_pkg::ChDot) || (ch == sth_pkg::ChAmp) ||
			(ch == sth_pkg::ChPlus) || (ch == sth_pkg::ChMinus) ||
			((ch == sth_pkg::ChUpH) && st.amp && !st.held)) begin
			cls = sth_pkg::CLS_NUMBER;
		end else begin
			cls = sth_pkg::CLS_TAG;
		end
		cur.cls = cls;

		if (done) begin
			res.cnt = 2'd2;
			res.r1.ch  = ch;
			res.r1.cls = sth_pkg::CLS_BREAK;
			res.r1.eot = 1'b0;
		end else if (hold) begin
			st_nxt.held = 1'b1;
			st_nxt.amp  = 1'b0;
		end else begin
			st_nxt.mode = mode;
			st_nxt.amp  = (ch == sth_pkg::ChAmp);
			if (st.held) begin
				res.cnt = 2'd2;
				res.r1  = cur;
			end else begin
				res.cnt = 2'd1;
				res.r0  = cur;
			end
		end

		if (last) begin
			if (res.cnt == 2'd2) begin
				res.r1.eot = 1'b1;
			end else begin
				res.r0.eot = 1'b1;
			end
			st_nxt = '{mode: sth_pkg::MODE_OUTSIDE, held: 1'b0, amp: 1'b0};
		end
	end

endmodule

FILE: hdl/sth_result_q.sv
// ----------------------------------------------------------------------------
// sth_result_q
// Four-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module sth_result_q (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sth_pkg::res_pair_t din,
	output logic               room,
	output logic               valid,
	input  logic               pop,
	output sth_pkg::res_t      dout
);

	sth_pkg::res_t mem_q [4];
	logic [1:0]    wp_q;
	logic [1:0]    rp_q;
	logic [2:0]    cnt_q;
	logic [1:0]    nadd;
	logic          take;

	assign nadd  = push ? din.cnt : 2'd0;
	assign valid = (cnt_q != 3'd0);
	assign take  = pop && valid;
	assign room  = (cnt_q <= 3'd2);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + nadd;
			rp_q  <= rp_q + {1'b0, take};
			cnt_q <= cnt_q + {1'b0, nadd} - {2'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		if (nadd != 2'd0) begin
			mem_q[wp_q] <= din.r0;
		end
		if (nadd == 2'd2) begin
			mem_q[wp_q + 2'd1] <= din.r1;
		end
	end

endmodule

FILE: hdl/subtitle_tag_highlighter.sv
// ----------------------------------------------------------------------------
// subtitle_tag_highlighter
// Styles subtitle text per character: override braces, tag separators,
// numbers, tag names, sticky brace errors and backslash line breaks.
//
//  channel | dir | tdata          | tuser          | tlast
//  s_*     | in  | code_unit      | -              | last_char
//  m_*     | out | char_out       | style_class    | end_of_text
//
// One character accepted per cycle; results pass input register, then queue.
// A character giving two results (line-break pair, released backslash)
// takes two output beats, so the output port sets the sustained rate.
// The input register stalls while fewer than two result queue slots are free.
// Reset clears mode, held backslash and the queue; the last beat returns
// mode, held backslash and ampersand memory to reset.
// ----------------------------------------------------------------------------
module subtitle_tag_highlighter #(
	parameter int unsigned CHAR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] code_unit
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] char_out
	output logic [2:0]  m_tuser,   // [2:0] style_class
	output logic        m_tlast
);

	localparam int unsigned CW = (CHAR_BITS < sth_pkg::CharW) ? CHAR_BITS : sth_pkg::CharW;

	logic                      valid_s1;
	logic [sth_pkg::CharW-1:0] ch_s1;
	logic                      last_s1;
	sth_pkg::st_t              st_q;
	sth_pkg::st_t              st_nxt;
	sth_pkg::res_pair_t        res;
	sth_pkg::res_t             head;
	logic                      room;
	logic                      adv;

	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '{mode: sth_pkg::MODE_OUTSIDE, held: 1'b0, amp: 1'b0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= sth_pkg::CharW'(s_tdata[CW-1:0]);
			last_s1 <= s_tlast;
		end
	end

	sth_classify u_cls (
		.ch     (ch_s1),
		.last   (last_s1),
		.st     (st_q),
		.res    (res),
		.st_nxt (st_nxt)
	);

	sth_result_q u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv),
		.din    (res),
		.room   (room),
		.valid  (m_tvalid),
		.pop    (m_tready),
		.dout   (head)
	);

	assign m_tdata = head.ch;
	assign m_tuser = head.cls;
	assign m_tlast = head.eot;

endmodule

FILE: hdl/sth_checker.sv
// ----------------------------------------------------------------------------
// sth_checker
// Port-level checks for the subtitle tag highlighter, bound to the top.
// ----------------------------------------------------------------------------
`include "subtitle_tag_highlighter_defines.svh"

module sth_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	`STH_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`STH_ASSERT_IMP(a_cls_range, m_tvalid, m_tuser != 3'd7)
	`STH_ASSERT_IMP(a_break_chars, m_tvalid && (m_tuser == sth_pkg::CLS_BREAK),
		(m_tdata == 16'h005C) || (m_tdata == 16'h006E) ||
		(m_tdata == 16'h004E) || (m_tdata == 16'h0068))
	`STH_ASSERT_IMP(a_empty_after_reset, $rose(arst_n), !m_tvalid)

endmodule

bind subtitle_tag_highlighter sth_checker u_sth_chk (.*);

FILE: test/tb_subtitle_tag_highlighter.sv
// ----------------------------------------------------------------------------
// Subtitle tag highlighter testbench
// Streams subtitle texts into the highlighter and checks every styled beat
// against a cycle-free model of the brace, separator, number, tag and
// line-break rules. Three short directed texts come first. Random texts follow,
// built from plain runs, backslash pairs and override blocks. The run steps
// through several sender and receiver idle mixes and one long output stall.
// ----------------------------------------------------------------------------
module tb_subtitle_tag_highlighter;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                      fin;
		logic [sth_pkg::CharW-1:0] ch;
	} char_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	subtitle_tag_highlighter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	char_beat_t                chars_to_send[$];
	logic [sth_pkg::CharW-1:0] text_buf[$];
	sth_pkg::res_t             styled_q[$];
	char_beat_t                next_beat;
	sth_pkg::res_t             want;

	// highlighter state as the testbench sees it
	sth_pkg::mode_t tb_mode = sth_pkg::MODE_OUTSIDE;
	logic           tb_held = 1'b0;
	logic           tb_amp = 1'b0;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  rx_hold = 1'b0;
	bit  in_ack = 1'b0;
	int  n_queued = 0;
	int  n_accepted = 0;
	int  n_results = 0;
	int  n_texts = 0;
	int  n_breaks = 0;
	int  n_fail = 0;

	function automatic sth_pkg::cls_t style_of(input logic [sth_pkg::CharW-1:0] c);
		sth_pkg::cls_t k;
		if (tb_mode != sth_pkg::MODE_OUTSIDE && tb_mode != sth_pkg::MODE_INSIDE) begin
			k = sth_pkg::CLS_ERROR;
		end else if (c == sth_pkg::ChOpen) begin
			if (tb_mode == sth_pkg::MODE_OUTSIDE) begin
				tb_mode = sth_pkg::MODE_INSIDE;
				k = sth_pkg::CLS_BRACE;
			end else begin
				tb_mode = sth_pkg::MODE_ERROR;
				k = sth_pkg::CLS_ERROR;
			end
		end else if (c == sth_pkg::ChClose) begin
			if (tb_mode == sth_pkg::MODE_INSIDE) begin
				tb_mode = sth_pkg::MODE_OUTSIDE;
				k = sth_pkg::CLS_BRACE;
			end else begin
				tb_mode = sth_pkg::MODE_ERROR;
				k = sth_pkg::CLS_ERROR;
			end
		end else if (tb_mode == sth_pkg::MODE_OUTSIDE) begin
			k = sth_pkg::CLS_NORMAL;
		end else if (c == sth_pkg::ChBslash || c == sth_pkg::ChLParen ||
				c == sth_pkg::ChRParen || c == sth_pkg::ChComma) begin
			k = sth_pkg::CLS_SEP;
		end else if ((c >= sth_pkg::ChZero && c <= sth_pkg::ChNine) ||
				c == sth_pkg::ChDot || c == sth_pkg::ChAmp ||
				c == sth_pkg::ChPlus || c == sth_pkg::ChMinus ||
				(c == sth_pkg::ChUpH && tb_amp)) begin
			k = sth_pkg::CLS_NUMBER;
		end else begin
			k = sth_pkg::CLS_TAG;
		end
		tb_amp = (c == sth_pkg::ChAmp);
		return k;
	endfunction

	function automatic void predict_styles(input logic [sth_pkg::CharW-1:0] c, input logic fin);
		sth_pkg::res_t rs[2];
		int            n;
		bit            done;
		int            i;
		n = 0;
		done = 1'b0;
		if (tb_held) begin
			tb_held = 1'b0;
			if (c == sth_pkg::ChLowN || c == sth_pkg::ChUpN || c == sth_pkg::ChLowH) begin
				rs[0] = {sth_pkg::ChBslash, sth_pkg::CLS_BREAK, 1'b0};
				rs[1] = {c, sth_pkg::CLS_BREAK, 1'b0};
				n = 2;
				tb_amp = 1'b0;
				done = 1'b1;
				n_breaks++;
			end else begin
				rs[0] = {sth_pkg::ChBslash, sth_pkg::CLS_NORMAL, 1'b0};
				n = 1;
			end
		end
		if (!done) begin
			if (tb_mode == sth_pkg::MODE_OUTSIDE && c == sth_pkg::ChBslash && !fin) begin
				tb_held = 1'b1;
				tb_amp = 1'b0;
			end else begin
				rs[n] = {c, style_of(c), 1'b0};
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			if (fin && i == n - 1)
				rs[i].eot = 1'b1;
			styled_q.push_back(rs[i]);
		end
		if (fin) begin
			tb_mode = sth_pkg::MODE_OUTSIDE;
			tb_held = 1'b0;
			tb_amp = 1'b0;
		end
	endfunction

	// moves the text buffer into the send queue
	function automatic void flush_text(input bit fin);
		int i;
		for (i = 0; i < text_buf.size(); i++)
			chars_to_send.push_back({fin && (i == text_buf.size() - 1), text_buf[i]});
		n_queued += text_buf.size();
		if (fin)
			n_texts++;
		text_buf.delete();
	endfunction

	function automatic void add_string(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_buf.push_back({8'h00, s[i]});
	endfunction

	function automatic logic [sth_pkg::CharW-1:0] random_letter();
		return sth_pkg::CharW'(16'h0061 + $urandom_range(25));
	endfunction

	function automatic logic [sth_pkg::CharW-1:0] tag_char();
		logic [sth_pkg::CharW-1:0] c;
		case ($urandom_range(13))
			0:       c = sth_pkg::ChBslash;
			1:       c = sth_pkg::ChLParen;
			2:       c = sth_pkg::ChRParen;
			3:       c = sth_pkg::ChComma;
			4, 5:    c = sth_pkg::CharW'(sth_pkg::ChZero + $urandom_range(9));
			6:       c = sth_pkg::ChDot;
			7:       c = sth_pkg::ChAmp;
			8:       c = sth_pkg::ChUpH;
			9:       c = sth_pkg::ChPlus;
			10:      c = sth_pkg::ChMinus;
			11:      c = sth_pkg::CharW'($urandom);
			default: c = random_letter();
		endcase
		return c;
	endfunction

	function automatic void queue_text();
		int                        len;
		int                        k;
		int                        j;
		int                        pick;
		logic [sth_pkg::CharW-1:0] c;
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(8, 1);
		for (k = 0; k < len; k++) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				case ($urandom_range(5))
					0:       c = sth_pkg::CharW'($urandom);
					1:       c = sth_pkg::ChAmp;
					2:       c = sth_pkg::ChUpH;
					3:       c = sth_pkg::ChLowN;
					default: c = random_letter();
				endcase
				text_buf.push_back(c);
			end else if (pick < 50) begin
				text_buf.push_back(sth_pkg::ChBslash);
				case ($urandom_range(6))
					0:       c = sth_pkg::ChLowN;
					1:       c = sth_pkg::ChUpN;
					2:       c = sth_pkg::ChLowH;
					3:       c = sth_pkg::ChBslash;
					4:       c = sth_pkg::ChOpen;
					5:       c = sth_pkg::CharW'($urandom);
					default: c = random_letter();
				endcase
				text_buf.push_back(c);
			end else if (pick < 90) begin
				text_buf.push_back(sth_pkg::ChOpen);
				for (j = $urandom_range(8); j > 0; j--)
					text_buf.push_back(tag_char());
				if ($urandom_range(9) != 0)
					text_buf.push_back(sth_pkg::ChClose);
			end else begin
				case ($urandom_range(2))
					0:       c = sth_pkg::ChOpen;
					1:       c = sth_pkg::ChClose;
					default: c = sth_pkg::CharW'($urandom);
				endcase
				text_buf.push_back(c);
			end
		end
		flush_text(1'b1);
	endfunction

	task automatic drain();
		while (n_accepted != n_queued || styled_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_chars);
		int goal;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		goal = n_queued + n_chars;
		while (n_queued < goal)
			queue_text();
		drain();
	endtask

	// sender: new beat only once the current one has gone
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_ack) begin
			if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_beat = chars_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_beat.ch;
				s_tlast <= next_beat.fin;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || rx_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ack <= 1'b0;
		end else begin
			in_ack <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				n_accepted++;
				predict_styles(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				if (styled_q.size() == 0) begin
					$error("unexpected beat: char_out %h style_class %0d", m_tdata, m_tuser);
					n_fail++;
				end else begin
					want = styled_q.pop_front();
					if (m_tdata !== want.ch) begin
						$error("char_out: expected %h, got %h", want.ch, m_tdata);
						n_fail++;
					end
					if (m_tuser !== want.cls) begin
						$error("style_class: expected %0d, got %0d", want.cls, m_tuser);
						n_fail++;
					end
					if (m_tlast !== want.eot) begin
						$error("end_of_text: expected %0d, got %0d", want.eot, m_tlast);
						n_fail++;
					end
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every class, break pairs, released backslashes, brace errors
		add_string("{\\(9&HH,.-0}");
		add_string("\\n\\\\N\\h\\q");
		flush_text(1'b0);
		add_string("{{");
		text_buf.push_back(16'hFFFF);
		text_buf.push_back(sth_pkg::ChBslash);
		flush_text(1'b1);
		text_buf.push_back(16'h0000);
		text_buf.push_back(sth_pkg::ChBslash);
		flush_text(1'b1);
		text_buf.push_back(sth_pkg::ChClose);
		flush_text(1'b1);
		drain();

		run_phase(0, 0, 280);
		run_phase(66, 0, 280);
		run_phase(0, 66, 280);
		run_phase(37, 37, 280);

		// output held off while the sender keeps pushing
		rx_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		run_phase(0, 0, 120);

		$display("%0d characters in %0d texts, %0d styled beats checked, %0d line breaks",
			n_accepted, n_texts, n_results, n_breaks);
		$display("idle mixes: none, sender 66%%, receiver 66%%, both 37%%, long output stall");
		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: subtitle_tag_highlighter.f
+incdir+hdl
hdl/sth_pkg.sv
hdl/sth_classify.sv
hdl/sth_result_q.sv
hdl/subtitle_tag_highlighter.sv
hdl/sth_checker.sv
test/tb_subtitle_tag_highlighter.sv
